// ===== hdl/ses_pkg.sv =====
package ses_pkg;

    localparam int NUM_SCALES = 4;
    localparam int COEF_W     = 24;
    localparam int SCL_W      = 2;
    localparam int CNT_W      = 3;
    localparam int SUM_W      = COEF_W + $clog2(NUM_SCALES);
    localparam int NOFF_W     = COEF_W + CNT_W;
    localparam int NUM_W      = SUM_W + 1;
    localparam int DIFF_W     = NUM_W + 2;
    localparam int OUT_W      = 16;
    localparam int FRAC_W     = 12;
    localparam int PRE_W      = OUT_W - FRAC_W;
    localparam int CMP_W      = SUM_W + PRE_W;
    localparam int CFG_IDX_W  = 1;
    localparam int FRONT      = 4;
    localparam int DEPTH      = FRONT + OUT_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_CONTRAST_OFFSET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALES_IN_USE   = 1'd1;

    localparam logic [CNT_W-1:0] SCALES_RESET = CNT_W'(NUM_SCALES);
    localparam logic [OUT_W-1:0] OUT_MAX      = '1;

endpackage

// ===== hdl/symmetric_edge_strength_unit.sv =====
// Channel  | Handshake           | Word
// ---------+---------------------+--------------------------------------------
// s_       | s_valid / s_ready   | odd/even coefficients per scale, dominant_scale
// m_       | m_valid / m_ready   | edge_strength, zero_divisor
// cfg_     | cfg_wr_en           | cfg_index, cfg_wdata
//
// One word per cycle unless the output stalls. Four stages form the numerator and
// divisor, sixteen stages of a restoring divider give one quotient bit each, and
// one output register follows. Reset clears all valid bits and loads the register
// defaults. A stalled output holds its word; empty stages upstream still fill.
module symmetric_edge_strength_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [ses_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ses_pkg::COEF_W-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [ses_pkg::COEF_W-1:0]   s_odd_coef_0,
    input  logic signed [ses_pkg::COEF_W-1:0]   s_odd_coef_1,
    input  logic signed [ses_pkg::COEF_W-1:0]   s_odd_coef_2,
    input  logic signed [ses_pkg::COEF_W-1:0]   s_odd_coef_3,
    input  logic signed [ses_pkg::COEF_W-1:0]   s_even_coef_0,
    input  logic signed [ses_pkg::COEF_W-1:0]   s_even_coef_1,
    input  logic signed [ses_pkg::COEF_W-1:0]   s_even_coef_2,
    input  logic signed [ses_pkg::COEF_W-1:0]   s_even_coef_3,
    input  logic [ses_pkg::SCL_W-1:0]           s_dominant_scale,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ses_pkg::OUT_W-1:0]           m_edge_strength,
    output logic                                m_zero_divisor
);

    localparam int NS  = ses_pkg::NUM_SCALES;
    localparam int CW  = ses_pkg::COEF_W;
    localparam int SW  = ses_pkg::SUM_W;
    localparam int NW  = ses_pkg::NUM_W;
    localparam int OW  = ses_pkg::OUT_W;
    localparam int DEP = ses_pkg::DEPTH;
    localparam int FR  = ses_pkg::FRONT;

    // configuration
    logic [CW-1:0]                contrast_offset_reg;
    logic [ses_pkg::CNT_W-1:0]    scales_in_use_reg;
    logic [ses_pkg::CNT_W-1:0]    n_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            contrast_offset_reg <= '0;
            scales_in_use_reg   <= ses_pkg::SCALES_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ses_pkg::REG_CONTRAST_OFFSET: contrast_offset_reg <= cfg_wdata;
                ses_pkg::REG_SCALES_IN_USE:
                    scales_in_use_reg <= cfg_wdata[ses_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign n_eff = (scales_in_use_reg > ses_pkg::CNT_W'(NS)) ? ses_pkg::CNT_W'(NS)
                                                            : scales_in_use_reg;

    // valid chain, bubbles collapse
    logic [DEP-1:0] vld_reg;
    logic [DEP-1:0] vld_next;
    logic [DEP-1:0] en;

    always_comb begin
        en[DEP-1] = !vld_reg[DEP-1] || m_ready;
        for (int i = DEP - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next[0] = en[0] ? s_valid : vld_reg[0];
        for (int i = 1; i < DEP; i++) begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[DEP-1];

    // stage 1: absolute values, dominant floor, scale masking
    logic signed [CW-1:0] odd_in [NS];
    logic signed [CW-1:0] even_in [NS];
    logic [CW-1:0]        abs_odd [NS];
    logic [ses_pkg::SCL_W-1:0] dom;
    logic [CW-1:0]        pci;

    logic signed [CW-1:0] odd1_reg [NS];
    logic signed [CW-1:0] even1_reg [NS];
    logic [CW-1:0]        dterm1_reg [NS];

    assign odd_in[0]  = s_odd_coef_0;
    assign odd_in[1]  = s_odd_coef_1;
    assign odd_in[2]  = s_odd_coef_2;
    assign odd_in[3]  = s_odd_coef_3;
    assign even_in[0] = s_even_coef_0;
    assign even_in[1] = s_even_coef_1;
    assign even_in[2] = s_even_coef_2;
    assign even_in[3] = s_even_coef_3;

    always_comb begin
        for (int s = 0; s < NS; s++) begin
            abs_odd[s] = odd_in[s][CW-1] ? CW'(-odd_in[s]) : CW'(odd_in[s]);
        end
        dom = ({1'b0, s_dominant_scale} >= (ses_pkg::SCL_W + 1)'(NS))
            ? ses_pkg::SCL_W'(NS - 1) : s_dominant_scale;
        pci = abs_odd[dom];
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int s = 0; s < NS; s++) begin
                if (ses_pkg::CNT_W'(s) < n_eff) begin
                    odd1_reg[s]   <= odd_in[s];
                    even1_reg[s]  <= even_in[s];
                    dterm1_reg[s] <= (abs_odd[s] > pci) ? abs_odd[s] : pci;
                end else begin
                    odd1_reg[s]   <= '0;
                    even1_reg[s]  <= '0;
                    dterm1_reg[s] <= '0;
                end
            end
        end
    end

    // stage 2: sums over scales, offset times count
    logic signed [SW-1:0]             odd_sum;
    logic signed [SW-1:0]             even_sum;
    logic [SW-1:0]                    div_sum;
    logic signed [SW-1:0]             odd2_reg;
    logic signed [SW-1:0]             even2_reg;
    logic [SW-1:0]                    div2_reg;
    logic [ses_pkg::NOFF_W-1:0]       noff2_reg;

    always_comb begin
        odd_sum  = '0;
        even_sum = '0;
        div_sum  = '0;
        for (int s = 0; s < NS; s++) begin
            odd_sum  = odd_sum + SW'(odd1_reg[s]);
            even_sum = even_sum + SW'(even1_reg[s]);
            div_sum  = div_sum + SW'(dterm1_reg[s]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            odd2_reg  <= odd_sum;
            even2_reg <= even_sum;
            div2_reg  <= div_sum;
            noff2_reg <= ses_pkg::NOFF_W'(n_eff) * ses_pkg::NOFF_W'(contrast_offset_reg);
        end
    end

    // stage 3: numerator, clamped at zero
    logic [SW-1:0]                   abs_sum;
    logic signed [ses_pkg::DIFF_W-1:0] diff;
    logic [NW-1:0]                   num3_reg;
    logic [SW-1:0]                   div3_reg;

    always_comb begin
        abs_sum = odd2_reg[SW-1] ? SW'(-odd2_reg) : SW'(odd2_reg);
        diff = $signed({{(ses_pkg::DIFF_W - SW){1'b0}}, abs_sum})
             - ses_pkg::DIFF_W'(even2_reg)
             - $signed({{(ses_pkg::DIFF_W - ses_pkg::NOFF_W){1'b0}}, noff2_reg});
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            num3_reg <= diff[ses_pkg::DIFF_W-1] ? '0 : diff[NW-1:0];
            div3_reg <= div2_reg;
        end
    end

    // stage 4: zero and saturation checks, divider seed
    logic                             sat_now;
    logic                             zero_now;
    logic [SW-1:0]                    rem4_reg;
    logic [OW-1:0]                    bits4_reg;
    logic [SW-1:0]                    div4_reg;
    logic                             sat4_reg;
    logic                             zero4_reg;

    assign zero_now = (div3_reg == '0);
    assign sat_now  = (ses_pkg::CMP_W'(num3_reg) >= {div3_reg, {ses_pkg::PRE_W{1'b0}}});

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            rem4_reg  <= (sat_now || zero_now) ? '0
                       : SW'(num3_reg[NW-1:ses_pkg::PRE_W]);
            bits4_reg <= {num3_reg[ses_pkg::PRE_W-1:0], {ses_pkg::FRAC_W{1'b0}}};
            div4_reg  <= div3_reg;
            sat4_reg  <= sat_now;
            zero4_reg <= zero_now;
        end
    end

    // divider: one quotient bit per stage
    logic [SW-1:0] rem_reg  [OW];
    logic [OW-1:0] bits_reg [OW];
    logic [OW-1:0] quo_reg  [OW];
    logic [SW-1:0] div_reg  [OW];
    logic          sat_reg  [OW];
    logic          zero_reg [OW];

    for (genvar k = 0; k < OW; k++) begin : g_div
        logic [SW-1:0] rem_in;
        logic [OW-1:0] bits_in;
        logic [OW-1:0] quo_in;
        logic [SW-1:0] div_in;
        logic          sat_in;
        logic          zero_in;
        logic [SW:0]   trial;
        logic          take;

        if (k == 0) begin : g_first
            assign rem_in  = rem4_reg;
            assign bits_in = bits4_reg;
            assign quo_in  = '0;
            assign div_in  = div4_reg;
            assign sat_in  = sat4_reg;
            assign zero_in = zero4_reg;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign bits_in = bits_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign div_in  = div_reg[k-1];
            assign sat_in  = sat_reg[k-1];
            assign zero_in = zero_reg[k-1];
        end

        assign trial = {rem_in, bits_in[OW-1]};
        assign take  = (trial >= {1'b0, div_in});

        always_ff @(posedge aclk) begin
            if (en[FR + k]) begin
                rem_reg[k]  <= take ? SW'(trial - {1'b0, div_in}) : SW'(trial);
                bits_reg[k] <= {bits_in[OW-2:0], 1'b0};
                quo_reg[k]  <= {quo_in[OW-2:0], take};
                div_reg[k]  <= div_in;
                sat_reg[k]  <= sat_in;
                zero_reg[k] <= zero_in;
            end
        end
    end

    // output register
    logic [OW-1:0] edge_reg;
    logic          zdiv_reg;

    always_ff @(posedge aclk) begin
        if (en[DEP-1]) begin
            zdiv_reg <= zero_reg[OW-1];
            if (zero_reg[OW-1]) begin
                edge_reg <= '0;
            end else if (sat_reg[OW-1]) begin
                edge_reg <= ses_pkg::OUT_MAX;
            end else begin
                edge_reg <= quo_reg[OW-1];
            end
        end
    end

    assign m_edge_strength = edge_reg;
    assign m_zero_divisor  = zdiv_reg;

endmodule

// ===== tb/sv/symmetric_edge_strength_unit_tb.sv =====
module symmetric_edge_strength_unit_tb;
    import ses_pkg::*;

    localparam int  IDLE_PCT    = 29;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  SETTLE      = DEPTH + 8;
    localparam int  MAX_REPORTS = 10;

    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic [COEF_W-1:0]        OFFSET_MAX = '1;

    typedef struct {
        logic signed [COEF_W-1:0] odd  [NUM_SCALES];
        logic signed [COEF_W-1:0] even [NUM_SCALES];
        logic [SCL_W-1:0]         dom;
    } pixel_word_t;

    typedef struct {
        logic [OUT_W-1:0] strength;
        logic             zero_div;
    } strength_word_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                        cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [COEF_W-1:0]           cfg_wdata = '0;

    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic signed [COEF_W-1:0]    s_odd_coef_0 = '0;
    logic signed [COEF_W-1:0]    s_odd_coef_1 = '0;
    logic signed [COEF_W-1:0]    s_odd_coef_2 = '0;
    logic signed [COEF_W-1:0]    s_odd_coef_3 = '0;
    logic signed [COEF_W-1:0]    s_even_coef_0 = '0;
    logic signed [COEF_W-1:0]    s_even_coef_1 = '0;
    logic signed [COEF_W-1:0]    s_even_coef_2 = '0;
    logic signed [COEF_W-1:0]    s_even_coef_3 = '0;
    logic [SCL_W-1:0]            s_dominant_scale = '0;

    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [OUT_W-1:0]            m_edge_strength;
    logic                        m_zero_divisor;

    // shadow of the block's registers
    logic [COEF_W-1:0]           offset_shadow = '0;
    logic [CNT_W-1:0]            scale_count_shadow = SCALES_RESET;

    strength_word_t              expected_strengths[$];
    int                          mismatch_count = 0;
    int                          cycle_count = 0;
    bit                          no_idle = 1'b0;

    symmetric_edge_strength_unit u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_odd_coef_0     (s_odd_coef_0),
        .s_odd_coef_1     (s_odd_coef_1),
        .s_odd_coef_2     (s_odd_coef_2),
        .s_odd_coef_3     (s_odd_coef_3),
        .s_even_coef_0    (s_even_coef_0),
        .s_even_coef_1    (s_even_coef_1),
        .s_even_coef_2    (s_even_coef_2),
        .s_even_coef_3    (s_even_coef_3),
        .s_dominant_scale (s_dominant_scale),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_edge_strength  (m_edge_strength),
        .m_zero_divisor   (m_zero_divisor)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, expected_strengths.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // normalized edge measure for one pixel under the current register settings
    function automatic strength_word_t edge_strength_of(pixel_word_t w);
        strength_word_t r;
        int             n;
        longint         floor_mag, odd_sum, even_sum, divisor, numer, o, m;
        longint         quot;
        n         = (scale_count_shadow > NUM_SCALES) ? NUM_SCALES : int'(scale_count_shadow);
        floor_mag = magnitude(longint'(w.odd[w.dom]));
        odd_sum   = 0;
        even_sum  = 0;
        divisor   = 0;
        for (int s = 0; s < n; s++) begin
            o        = longint'(w.odd[s]);
            m        = magnitude(o);
            odd_sum  += o;
            even_sum += longint'(w.even[s]);
            divisor  += (m > floor_mag) ? m : floor_mag;
        end
        numer = magnitude(odd_sum) - even_sum - longint'(n) * longint'({1'b0, offset_shadow});
        if (numer < 0)
            numer = 0;
        if (divisor == 0) begin
            r.strength = '0;
            r.zero_div = 1'b1;
        end else begin
            quot       = (numer * 4096) / divisor;
            r.strength = (quot > longint'(OUT_MAX)) ? OUT_MAX : OUT_W'(quot);
            r.zero_div = 1'b0;
        end
        return r;
    endfunction

    task automatic note_mismatch(string what, longint exp_v, longint act_v);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s expected %0d actual %0d",
                     cycle_count, what, exp_v, act_v);
    endtask

    // check each accepted result word against the oldest prediction
    always @(posedge aclk) begin
        strength_word_t exp_w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_strengths.size() == 0) begin
                note_mismatch("unexpected word, edge_strength", -1, m_edge_strength);
            end else begin
                exp_w = expected_strengths.pop_front();
                if (m_edge_strength !== exp_w.strength)
                    note_mismatch("edge_strength", exp_w.strength, m_edge_strength);
                if (m_zero_divisor !== exp_w.zero_div)
                    note_mismatch("zero_divisor", exp_w.zero_div, m_zero_divisor);
            end
        end
    end

    task automatic send_pixel(pixel_word_t w);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_odd_coef_0     <= w.odd[0];
        s_odd_coef_1     <= w.odd[1];
        s_odd_coef_2     <= w.odd[2];
        s_odd_coef_3     <= w.odd[3];
        s_even_coef_0    <= w.even[0];
        s_even_coef_1    <= w.even[1];
        s_even_coef_2    <= w.even[2];
        s_even_coef_3    <= w.even[3];
        s_dominant_scale <= w.dom;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        expected_strengths.push_back(edge_strength_of(w));
    endtask

    // drop valid and hold until every predicted word has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_strengths.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_CONTRAST_OFFSET)
            offset_shadow = data;
        else
            scale_count_shadow = data[CNT_W-1:0];
    endtask

    function automatic pixel_word_t make_pixel(
        logic signed [COEF_W-1:0] o0, logic signed [COEF_W-1:0] o1,
        logic signed [COEF_W-1:0] o2, logic signed [COEF_W-1:0] o3,
        logic signed [COEF_W-1:0] e0, logic signed [COEF_W-1:0] e1,
        logic signed [COEF_W-1:0] e2, logic signed [COEF_W-1:0] e3,
        logic [SCL_W-1:0] dom);
        pixel_word_t w;
        w.odd[0]  = o0; w.odd[1]  = o1; w.odd[2]  = o2; w.odd[3]  = o3;
        w.even[0] = e0; w.even[1] = e1; w.even[2] = e2; w.even[3] = e3;
        w.dom     = dom;
        return w;
    endfunction

    function automatic logic signed [COEF_W-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return COEF_MAX;
            1:       return COEF_MIN;
            2:       return '0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    function automatic logic signed [COEF_W-1:0] narrow_coef(int span);
        return COEF_W'(longint'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic pixel_word_t random_pixel();
        pixel_word_t w;
        int          mode;
        mode  = $urandom_range(0, 9);
        w.dom = SCL_W'($urandom);
        for (int s = 0; s < NUM_SCALES; s++) begin
            case (mode)
                0, 1, 2, 3: begin
                    w.odd[s]  = COEF_W'($urandom);
                    w.even[s] = COEF_W'($urandom);
                end
                4, 5, 6: begin
                    w.odd[s]  = narrow_coef(1 << 14);
                    w.even[s] = narrow_coef(1 << 12);
                end
                7: begin
                    // all-zero odd side forces a zero divisor
                    w.odd[s]  = '0;
                    w.even[s] = COEF_W'($urandom);
                end
                8: begin
                    // aligned odd side and negative evens push toward saturation
                    w.odd[s]  = COEF_W'($urandom_range(0, 1 << 20));
                    w.even[s] = -COEF_W'($urandom_range(0, 1 << 22));
                end
                default: begin
                    w.odd[s]  = pick_extreme();
                    w.even[s] = pick_extreme();
                end
            endcase
        end
        return w;
    endfunction

    task automatic test_field_extremes();
        send_pixel(make_pixel(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX,
                              COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 2'd3));
        send_pixel(make_pixel(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN,
                              COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 2'd0));
        send_pixel(make_pixel(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX,
                              COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 2'd1));
        send_pixel(make_pixel(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN,
                              COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 2'd2));
        send_pixel(make_pixel(-1, -1, -1, -1, -1, -1, -1, -1, 2'd0));
        send_pixel(make_pixel(1, 1, 1, 1, 1, 1, 1, 1, 2'd3));
        send_pixel(make_pixel(COEF_MAX, COEF_MIN, 4096, -4096, 0, 0, 0, 0, 2'd1));
    endtask

    task automatic test_dominant_scale();
        // dominant odd magnitude sets the floor of each divisor term
        for (int d = 0; d < NUM_SCALES; d++)
            send_pixel(make_pixel(4096, -8192, 20480, -409, -2048, 1024, 0, 512,
                                  SCL_W'(d)));
    endtask

    task automatic test_zero_divisor();
        send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0, 0, 2'd0));
        send_pixel(make_pixel(0, 0, 0, 0, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 2'd2));
        write_reg(REG_SCALES_IN_USE, COEF_W'(0));
        send_pixel(make_pixel(COEF_MAX, 7, -7, COEF_MIN, COEF_MIN, 0, 0, 0, 2'd1));
        send_pixel(make_pixel(1, 2, 3, 4, 5, 6, 7, 8, 2'd3));
    endtask

    task automatic test_scale_count();
        // counts above the scale total clamp to it
        write_reg(REG_SCALES_IN_USE, COEF_W'(7));
        send_pixel(make_pixel(8192, 4096, -4096, 100, -300, 200, 0, 0, 2'd0));
        write_reg(REG_SCALES_IN_USE, COEF_W'(1));
        send_pixel(make_pixel(8192, 4096, -4096, 100, -300, 200, 0, 0, 2'd0));
        // dominant scale outside the summed range still floors the divisor
        send_pixel(make_pixel(8192, 4096, -4096, 100000, -300, 200, 0, 0, 2'd3));
        write_reg(REG_SCALES_IN_USE, COEF_W'(2));
        send_pixel(make_pixel(8192, 4096, -4096, 100, -300, 200, 0, 0, 2'd2));
    endtask

    task automatic test_contrast_offset();
        write_reg(REG_SCALES_IN_USE, COEF_W'(4));
        write_reg(REG_CONTRAST_OFFSET, OFFSET_MAX);
        send_pixel(make_pixel(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX,
                              COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 2'd0));
        send_pixel(make_pixel(4096, 4096, 4096, 4096, 0, 0, 0, 0, 2'd1));
        write_reg(REG_CONTRAST_OFFSET, COEF_W'(1024));
        send_pixel(make_pixel(4096, 4096, 4096, 4096, 0, 0, 0, 0, 2'd1));
        send_pixel(make_pixel(4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 2'd2));
    endtask

    task automatic run_random_phase(logic [COEF_W-1:0] offset, int scale_count,
                                    int count, bit steady, bit pause_midway);
        write_reg(REG_CONTRAST_OFFSET, offset);
        write_reg(REG_SCALES_IN_USE, COEF_W'(scale_count));
        no_idle = steady;
        for (int i = 0; i < count; i++) begin
            if (pause_midway && i == count / 2)
                wait_drained();
            send_pixel(random_pixel());
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_pixels();
        run_random_phase('0, 4, 250, 1'b0, 1'b0);
        run_random_phase(COEF_W'($urandom_range(0, 1 << 16)), 4, 250, 1'b1, 1'b0);
        run_random_phase('0, 1, 200, 1'b0, 1'b1);
        run_random_phase(COEF_W'($urandom_range(0, 1 << 20)), 2, 200, 1'b0, 1'b0);
        run_random_phase(COEF_W'($urandom_range(0, 1 << 12)), 3, 200, 1'b0, 1'b0);
        run_random_phase(OFFSET_MAX, 4, 100, 1'b0, 1'b0);
        run_random_phase(COEF_W'($urandom_range(0, 1 << 14)), 6, 250, 1'b0, 1'b0);
        run_random_phase('0, 0, 50, 1'b0, 1'b0);
        run_random_phase(COEF_W'($urandom), 5, 100, 1'b0, 1'b0);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_field_extremes();
        test_dominant_scale();
        test_zero_divisor();
        test_scale_count();
        test_contrast_offset();
        test_random_pixels();

        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (mismatch_count == 0 && expected_strengths.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
